// ----- sv/bbc_pkg.sv -----
// Package for the bracket balance checker: codes, bracket kinds, classifier.
`timescale 1ns / 1ps
package bbc_pkg;

  localparam int STACK_DEPTH_DEF = 128;

  // Result / failure codes
  typedef logic [2:0] err_code_t;
  localparam err_code_t ERR_OK       = 3'd0;
  localparam err_code_t ERR_MISMATCH = 3'd1;
  localparam err_code_t ERR_EMPTY    = 3'd2;
  localparam err_code_t ERR_UNCLOSED = 3'd3;
  localparam err_code_t ERR_OVERFLOW = 3'd4;

  // Bracket kinds as stored on the stack
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ROUND  = 2'd0;
  localparam kind_t KIND_SQUARE = 2'd1;
  localparam kind_t KIND_CURLY  = 2'd2;

  localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;  // (
  localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;  // )
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;  // [
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;  // ]
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;  // {
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;  // }

  typedef struct packed {
    logic  is_bracket;
    logic  is_open;
    kind_t kind;
  } char_class_t;

  function automatic char_class_t bbc_classify(logic [7:0] c);
    char_class_t r;
    r = '{is_bracket: 1'b1, is_open: 1'b0, kind: KIND_ROUND};
    case (c)
      CH_OPEN_ROUND: begin
        r.is_open = 1'b1;
        r.kind    = KIND_ROUND;
      end
      CH_OPEN_SQUARE: begin
        r.is_open = 1'b1;
        r.kind    = KIND_SQUARE;
      end
      CH_OPEN_CURLY: begin
        r.is_open = 1'b1;
        r.kind    = KIND_CURLY;
      end
      CH_CLOSE_ROUND:  r.kind = KIND_ROUND;
      CH_CLOSE_SQUARE: r.kind = KIND_SQUARE;
      CH_CLOSE_CURLY:  r.kind = KIND_CURLY;
      default:         r.is_bracket = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/bbc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 128,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/bracket_balance_checker.sv -----
// Top level of the bracket balance checker: stack control, RAM and result register.
`timescale 1ns / 1ps
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------
//  in      | input     | in_valid / in_stall  | char_present, ch, last
//  out     | output    | out_valid / out_stall| balanced, error_code
//
//  One input transaction per cycle, sustained while in_stall is low; a result
//  appears in the cycle after the transaction marked last. The rate is set
//  by the top-of-stack register plus a RAM read of the entry below the
//  top, issued each cycle for the next level, so a pop has its new top ready at once.
//  Reset (rst, synchronous) clears level, failure and the output valid;
//  the stack RAM is not cleared and needs no clearing pass.
//  in_stall rises only for a last transaction while a result waits stalled.
//
module bracket_balance_checker #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               char_present,
  input  logic [7:0]         ch,
  input  logic               last,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               balanced,
  output bbc_pkg::err_code_t error_code
);
  import bbc_pkg::*;

  localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(STACK_DEPTH);
  localparam logic [LEVEL_W-1:0] LEVEL_ONE  = LEVEL_W'(1);
  localparam logic [LEVEL_W-1:0] LEVEL_TWO  = LEVEL_W'(2);

  // stack state: level, sticky failure, and the top entry in a register
  logic [LEVEL_W-1:0] level, level_next;
  err_code_t          failure, failure_next;
  kind_t              top, top_next;

  // RAM holds every pushed entry at its level; below = mem[level-2]
  logic              push;
  logic [ADDR_W-1:0] raddr;
  kind_t             below;

  char_class_t cls;
  logic        in_accept;
  logic        take;
  logic        res_fire;
  err_code_t   res_code;
  logic        out_valid_next;

  // Only a last transaction produces a result, so only it must wait.
  assign in_stall  = out_valid & out_stall & last;
  assign in_accept = in_valid & ~in_stall;
  assign cls       = bbc_classify(ch);
  assign take      = in_accept & char_present & (failure == ERR_OK) & cls.is_bracket;
  assign res_fire  = in_accept & last;

  always_comb begin
    level_next   = level;
    failure_next = failure;
    top_next     = top;
    push         = 1'b0;
    res_code     = ERR_OK;

    if (take) begin
      if (cls.is_open) begin
        if (level == LEVEL_FULL) begin
          failure_next = ERR_OVERFLOW;
        end else begin
          push       = 1'b1;
          top_next   = cls.kind;
          level_next = level + LEVEL_ONE;
        end
      end else begin
        if (level == '0) begin
          failure_next = ERR_EMPTY;
        end else begin
          level_next = level - LEVEL_ONE;
          top_next   = below;
          if (top != cls.kind) begin
            failure_next = ERR_MISMATCH;
          end
        end
      end
    end

    if (res_fire) begin
      if (failure_next != ERR_OK) begin
        res_code = failure_next;
      end else if (level_next != '0) begin
        res_code = ERR_UNCLOSED;
      end
      level_next   = '0;
      failure_next = ERR_OK;
    end
  end

  // Prefetch the entry under the next top; garbage when level_next < 2,
  // never used then. Meets this cycle's write address only at a string end.
  logic [LEVEL_W-1:0] raddr_full;
  assign raddr_full = level_next - LEVEL_TWO;
  assign raddr      = raddr_full[ADDR_W-1:0];

  bbc_ram #(
    .WIDTH ($bits(kind_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (push),
    .waddr (level[ADDR_W-1:0]),
    .wdata (cls.kind),
    .raddr (raddr),
    .rdata (below)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      level   <= '0;
      failure <= ERR_OK;
    end else begin
      level   <= level_next;
      failure <= failure_next;
    end
    top <= top_next;
  end

  // result register
  always_comb begin
    out_valid_next = out_valid & out_stall;
    if (res_fire) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
    if (res_fire) begin
      balanced   <= (res_code == ERR_OK);
      error_code <= res_code;
    end
  end

  // checks
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LEVEL_FULL)
    else $error("stack level beyond depth");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    res_fire |=> (level == '0) && (failure == ERR_OK))
    else $error("stack or failure not cleared after last");

  a_balanced_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (balanced == (error_code == ERR_OK)))
    else $error("balanced flag disagrees with error code");

  a_failure_freezes: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !last && failure != ERR_OK) |=> $stable(level) && $stable(failure))
    else $error("stack changed after sticky failure");

  a_no_result_lost: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(error_code))
    else $error("stalled result dropped or changed");

endmodule

// ----- tb/tb_bracket_balance_checker.sv -----
// Self-checking testbench for the bracket balance checker: directed and random strings.
`timescale 1ns / 1ps
module tb_bracket_balance_checker;
  import bbc_pkg::*;

  // No acceptance on either channel for this many cycles ends the run.
  // The longest legal quiet stretch is the receiver hold-off below, plus any
  // random stalls that follow it, so this leaves a wide margin.
  localparam int QUIET_LIMIT = 4000;
  // Receiver hold-off used to back up the block until in_stall rises.
  localparam int HOLD_CYCLES = 400;
  // Per-phase size of the random part, counted in transactions.
  localparam int PHASE_ITEMS = 380;

  typedef struct {
    logic       char_present;
    logic [7:0] ch;
    logic       last;
  } item_t;

  typedef struct {
    logic      balanced;
    err_code_t code;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       char_present = 1'b0;
  logic [7:0] ch = 8'h00;
  logic       last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       balanced;
  err_code_t  error_code;

  // Stimulus queue (filled by the initial block, drained by the driver) and
  // the expected verdicts, one per string end, oldest first.
  item_t      char_items[$];
  verdict_t   expected_verdicts[$];
  logic [7:0] text_q[$];
  int         stim_count = 0;
  int         mismatches = 0;

  // Idle/stall rates in percent, changed per phase.
  int         send_idle_pct = 31;
  int         recv_stall_pct = 60;
  logic       hold_req = 1'b0;
  logic       hold_done = 1'b0;
  int         hold_left = 0;
  int         quiet_cycles = 0;

  // Shadow of the checker state: open bracket kinds, depth, sticky failure.
  kind_t       open_kinds [STACK_DEPTH_DEF];
  int unsigned open_depth = 0;
  err_code_t   sticky_code = ERR_OK;

  item_t      next_item;

  bracket_balance_checker dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_present (char_present),
    .ch           (ch),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .balanced     (balanced),
    .error_code   (error_code)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Sorts a byte into bracket / not bracket, opening / closing, and kind.
  function automatic void sort_char(input logic [7:0] c, output logic hit,
                                    output logic opens, output kind_t k);
    hit   = 1'b1;
    opens = 1'b0;
    k     = KIND_ROUND;
    case (c)
      CH_OPEN_ROUND:   opens = 1'b1;
      CH_OPEN_SQUARE: begin
        opens = 1'b1;
        k     = KIND_SQUARE;
      end
      CH_OPEN_CURLY: begin
        opens = 1'b1;
        k     = KIND_CURLY;
      end
      CH_CLOSE_ROUND:  k = KIND_ROUND;
      CH_CLOSE_SQUARE: k = KIND_SQUARE;
      CH_CLOSE_CURLY:  k = KIND_CURLY;
      default:         hit = 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] bracket_char(kind_t k, bit opening);
    case (k)
      KIND_ROUND:  return opening ? CH_OPEN_ROUND : CH_CLOSE_ROUND;
      KIND_SQUARE: return opening ? CH_OPEN_SQUARE : CH_CLOSE_SQUARE;
      default:     return opening ? CH_OPEN_CURLY : CH_CLOSE_CURLY;
    endcase
  endfunction

  // Applies one accepted transaction to the shadow state; a string end
  // yields the verdict and clears depth and failure.
  function automatic void advance_balance(logic cp, logic [7:0] c, logic lst);
    verdict_t v;
    logic     hit;
    logic     opens;
    kind_t    k;
    if (cp && sticky_code == ERR_OK) begin
      sort_char(c, hit, opens, k);
      if (hit && opens) begin
        if (open_depth == STACK_DEPTH_DEF) begin
          sticky_code = ERR_OVERFLOW;
        end else begin
          open_kinds[open_depth] = k;
          open_depth++;
        end
      end else if (hit) begin
        if (open_depth == 0) begin
          sticky_code = ERR_EMPTY;
        end else begin
          open_depth--;
          if (open_kinds[open_depth] != k) sticky_code = ERR_MISMATCH;
        end
      end
    end
    if (lst) begin
      if (sticky_code != ERR_OK) v.code = sticky_code;
      else if (open_depth != 0) v.code = ERR_UNCLOSED;
      else v.code = ERR_OK;
      v.balanced = (v.code == ERR_OK);
      expected_verdicts.push_back(v);
      open_depth  = 0;
      sticky_code = ERR_OK;
    end
  endfunction

  // Turns text_q into transactions. The end goes on the final character, or
  // on a separate empty marker when asked (or when the text is empty). Empty
  // transactions are sprinkled in now and then; they must change nothing.
  task automatic flush_string(bit marker);
    item_t it;
    for (int i = 0; i < text_q.size(); i++) begin
      if ($urandom_range(19) == 0) begin
        it = '{1'b0, 8'($urandom_range(255)), 1'b0};
        char_items.push_back(it);
        stim_count++;
      end
      it = '{1'b1, text_q[i], !marker && (i == text_q.size() - 1)};
      char_items.push_back(it);
      stim_count++;
    end
    if (marker || text_q.size() == 0) begin
      it = '{1'b0, 8'($urandom_range(255)), 1'b1};
      char_items.push_back(it);
      stim_count++;
    end
    text_q.delete();
  endtask

  task automatic queue_text(string s, bit marker);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    flush_string(marker);
  endtask

  // Nested brackets with filler. A broken string gets one fault: a wrong
  // closing kind, a stray close, or the tail left unclosed.
  task automatic build_nested(bit clean);
    kind_t      open_q[$];
    int         steps;
    int         fault_at;
    bit         leave_open;
    logic [7:0] c;
    logic       hit;
    logic       opens;
    kind_t      k;
    int         r;
    steps      = $urandom_range(1, 24);
    fault_at   = clean ? -1 : $urandom_range(0, steps - 1);
    leave_open = 1'b0;
    for (int i = 0; i < steps; i++) begin
      if (i == fault_at) begin
        case ($urandom_range(2))
          0: begin
            if (open_q.size() > 0) begin
              k = open_q.pop_back();
              text_q.push_back(bracket_char(kind_t'((k + 1) % 3), 1'b0));
            end else begin
              text_q.push_back(bracket_char(kind_t'($urandom_range(2)), 1'b0));
            end
          end
          1: text_q.push_back(bracket_char(kind_t'($urandom_range(2)), 1'b0));
          default: leave_open = 1'b1;
        endcase
      end else begin
        r = $urandom_range(9);
        if (r < 2) begin
          do begin
            c = 8'($urandom_range(255));
            sort_char(c, hit, opens, k);
          end while (hit);
          text_q.push_back(c);
        end else if (r < 6 || open_q.size() == 0) begin
          k = kind_t'($urandom_range(2));
          open_q.push_back(k);
          text_q.push_back(bracket_char(k, 1'b1));
        end else begin
          text_q.push_back(bracket_char(open_q.pop_back(), 1'b0));
        end
      end
    end
    if (!leave_open) begin
      while (open_q.size() > 0) text_q.push_back(bracket_char(open_q.pop_back(), 1'b0));
    end
  endtask

  // Deep nesting: up to the full stack, or past it for the overflow case.
  task automatic build_deep(int opens_n);
    kind_t open_q[$];
    kind_t k;
    for (int i = 0; i < opens_n; i++) begin
      k = kind_t'($urandom_range(2));
      open_q.push_back(k);
      text_q.push_back(bracket_char(k, 1'b1));
    end
    while (open_q.size() > 0) text_q.push_back(bracket_char(open_q.pop_back(), 1'b0));
  endtask

  task automatic fill_random(int amount);
    int goal;
    int r;
    goal = stim_count + amount;
    while (stim_count < goal) begin
      r = $urandom_range(99);
      if (r < 55) begin
        build_nested(1'b1);
      end else if (r < 80) begin
        build_nested(1'b0);
      end else if (r < 97) begin
        // raw bytes, brackets included by chance
        repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(255)));
      end else begin
        build_deep($urandom_range(100, 132));
      end
      flush_string($urandom_range(3) == 0);
    end
  endtask

  // Sampled on the falling edge, clear of the driver's updates.
  task automatic wait_for_idle();
    while (char_items.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(negedge clk);
  endtask

  // Driver: the prediction is taken from the transaction as it is accepted;
  // a stalled payload is held, otherwise the next item is offered or a gap
  // is inserted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) advance_balance(char_present, ch, last);
      if (!in_valid || !in_stall) begin
        if (char_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item    = char_items.pop_front();
          in_valid     <= 1'b1;
          char_present <= next_item.char_present;
          ch           <= next_item.ch;
          last         <= next_item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random, or a long hold-off once requested so results
  // back up and the block must stall its input on the next string end.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: each accepted result against the oldest expected verdict.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        $error("result with no string end pending: balanced=%0b error_code=%0d",
               balanced, error_code);
        mismatches++;
      end else begin
        if (balanced !== expected_verdicts[0].balanced) begin
          $error("balanced: expected %0b, got %0b", expected_verdicts[0].balanced, balanced);
          mismatches++;
        end
        if (error_code !== expected_verdicts[0].code) begin
          $error("error_code: expected %0d, got %0d", expected_verdicts[0].code, error_code);
          mismatches++;
        end
        void'(expected_verdicts.pop_front());
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed strings
    queue_text("", 1'b1);         // empty string, marker only
    queue_text("()", 1'b0);
    queue_text("[{}]", 1'b0);
    queue_text("(]", 1'b0);       // mismatch
    queue_text(")(", 1'b0);       // close on empty, then ignored
    queue_text("{", 1'b0);        // unclosed at end
    queue_text("((", 1'b1);       // unclosed, end on marker
    text_q = '{8'h00, 8'hFF};     // non-bracket bytes only
    flush_string(1'b1);
    queue_text("(}]", 1'b1);      // mismatch, rest ignored

    // Full depth and overflow are too long for the directed list; they
    // lead the random part.
    build_deep(STACK_DEPTH_DEF);
    flush_string(1'b0);
    build_deep(STACK_DEPTH_DEF + 1);
    flush_string(1'b1);

    fill_random(PHASE_ITEMS);
    wait_for_idle();

    send_idle_pct  <= 60;
    recv_stall_pct <= 31;
    fill_random(PHASE_ITEMS);
    wait_for_idle();

    // No idling from here on, opened by the long receiver hold-off.
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    hold_req       <= 1'b1;
    fill_random(PHASE_ITEMS);
    wait_for_idle();

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/bbc_pkg.sv
sv/bbc_ram.sv
sv/bracket_balance_checker.sv
tb/tb_bracket_balance_checker.sv
